// File: src/kgl_pkg.sv
// ----------------------------------------------------------------------------
// kgl_pkg
// Shared types, constants and saturating helpers for the glyph layout block.
// ----------------------------------------------------------------------------
package kgl_pkg;

  // Default geometry
  localparam int unsigned CHAR_BITS_DEF   = 7;
  localparam int unsigned METRIC_BITS_DEF = 16;

  // Fixed field widths
  localparam int unsigned SIZE_W     = 16;
  localparam int unsigned TEX_W      = 16;
  localparam int unsigned POS_W      = 32;
  localparam int unsigned HGT_W      = 31;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  // Result queue depth, also the bound on requests in flight
  localparam int unsigned FIFO_DEPTH = 4;

  // Fixed point: Q2.14 x Q12.4 -> Q15.4, rounded half up
  localparam int unsigned FRAC_SHIFT = 14;
  localparam int unsigned ROUND_BIAS = 8192;

  localparam int unsigned SPACE_CODE = 32;

  // Register reset values
  localparam logic [SIZE_W-1:0] FONT_SIZE_RST = 16'd256;
  localparam logic [SIZE_W-1:0] SPACE_ADV_RST = 16'd4096;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FONT_SIZE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SPACE_ADV = 2'd1;

  typedef enum logic [1:0] {
    OP_LOAD_GLYPH = 2'd0,
    OP_LOAD_KERN  = 2'd1,
    OP_START      = 2'd2,
    OP_LAYOUT     = 2'd3
  } op_e;

  // Issue control, top level to store
  typedef struct packed {
    logic valid;
    op_e  op;
    logic is_space;
  } iss_ctl_t;

  // Lookup control, store to datapath, in the cycle after issue
  typedef struct packed {
    logic valid;
    op_e  op;
    logic is_space;
    logic present;
    logic have_prev;
  } lkp_ctl_t;

  // One result
  typedef struct packed {
    logic                    quad_valid;
    logic signed [POS_W-1:0] quad_left;
    logic signed [POS_W-1:0] quad_right;
    logic signed [POS_W-1:0] quad_top;
    logic signed [POS_W-1:0] quad_bottom;
    logic [TEX_W-1:0]        out_s_low;
    logic [TEX_W-1:0]        out_t_low;
    logic [TEX_W-1:0]        out_s_high;
    logic [TEX_W-1:0]        out_t_high;
    logic signed [POS_W-1:0] pen_position;
    logic [HGT_W-1:0]        line_height;
  } res_t;

  localparam logic signed [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
  localparam logic signed [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};

  // Saturating signed add
  function automatic logic signed [POS_W-1:0] sat_add(input logic signed [POS_W-1:0] a,
                                                      input logic signed [POS_W-1:0] b);
    logic [POS_W:0] s;
    s = {a[POS_W-1], a} + {b[POS_W-1], b};
    if (s[POS_W] != s[POS_W-1]) begin
      return s[POS_W] ? POS_MIN : POS_MAX;
    end
    return s[POS_W-1:0];
  endfunction

  // Saturating signed subtract
  function automatic logic signed [POS_W-1:0] sat_sub(input logic signed [POS_W-1:0] a,
                                                      input logic signed [POS_W-1:0] b);
    logic [POS_W:0] s;
    s = {a[POS_W-1], a} - {b[POS_W-1], b};
    if (s[POS_W] != s[POS_W-1]) begin
      return s[POS_W] ? POS_MIN : POS_MAX;
    end
    return s[POS_W-1:0];
  endfunction

endpackage

// File: src/kgl_intf.sv
// ----------------------------------------------------------------------------
// kgl_intf
// Request, result and register write channels of the glyph layout block.
// ----------------------------------------------------------------------------

// Request channel: loads, string start and characters
interface kgl_req_if #(
  parameter int unsigned CHAR_BITS   = kgl_pkg::CHAR_BITS_DEF,
  parameter int unsigned METRIC_BITS = kgl_pkg::METRIC_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic [1:0]                    req_type;
  logic [CHAR_BITS-1:0]          char_code;
  logic [CHAR_BITS-1:0]          pair_char;
  logic signed [METRIC_BITS-1:0] advance_or_kern;
  logic signed [METRIC_BITS-1:0] box_width;
  logic signed [METRIC_BITS-1:0] box_height;
  logic signed [METRIC_BITS-1:0] bearing_left;
  logic signed [METRIC_BITS-1:0] bearing_top;
  logic [kgl_pkg::TEX_W-1:0]     tex_s_low;
  logic [kgl_pkg::TEX_W-1:0]     tex_t_low;
  logic [kgl_pkg::TEX_W-1:0]     tex_s_high;
  logic [kgl_pkg::TEX_W-1:0]     tex_t_high;

  modport source (
    output valid, req_type, char_code, pair_char, advance_or_kern, box_width,
           box_height, bearing_left, bearing_top, tex_s_low, tex_t_low,
           tex_s_high, tex_t_high,
    input  ready
  );
  modport sink (
    input  valid, req_type, char_code, pair_char, advance_or_kern, box_width,
           box_height, bearing_left, bearing_top, tex_s_low, tex_t_low,
           tex_s_high, tex_t_high,
    output ready
  );
endinterface

// Result channel: one quad record per request
interface kgl_quad_if;
  logic                             valid;
  logic                             ready;
  logic                             quad_valid;
  logic signed [kgl_pkg::POS_W-1:0] quad_left;
  logic signed [kgl_pkg::POS_W-1:0] quad_right;
  logic signed [kgl_pkg::POS_W-1:0] quad_top;
  logic signed [kgl_pkg::POS_W-1:0] quad_bottom;
  logic [kgl_pkg::TEX_W-1:0]        out_s_low;
  logic [kgl_pkg::TEX_W-1:0]        out_t_low;
  logic [kgl_pkg::TEX_W-1:0]        out_s_high;
  logic [kgl_pkg::TEX_W-1:0]        out_t_high;
  logic signed [kgl_pkg::POS_W-1:0] pen_position;
  logic [kgl_pkg::HGT_W-1:0]        line_height;

  modport source (
    output valid, quad_valid, quad_left, quad_right, quad_top, quad_bottom,
           out_s_low, out_t_low, out_s_high, out_t_high, pen_position, line_height,
    input  ready
  );
  modport sink (
    input  valid, quad_valid, quad_left, quad_right, quad_top, quad_bottom,
           out_s_low, out_t_low, out_s_high, out_t_high, pen_position, line_height,
    output ready
  );
endinterface

// Register write channel
interface kgl_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [kgl_pkg::CFG_IDX_W-1:0]     idx;
  logic [kgl_pkg::CFG_DATA_W-1:0]    wdata;

  modport source (output valid, idx, wdata, input ready);
  modport sink   (input valid, idx, wdata, output ready);
endinterface

// File: src/kgl_ram.sv
// ----------------------------------------------------------------------------
// kgl_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module kgl_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/kgl_store.sv
// ----------------------------------------------------------------------------
// kgl_store
// Glyph and kerning tables, glyph present bits, previous character and the
// kerning clear sweep after reset.
// ----------------------------------------------------------------------------
module kgl_store #(
  parameter int unsigned CHAR_BITS   = kgl_pkg::CHAR_BITS_DEF,
  parameter int unsigned METRIC_BITS = kgl_pkg::METRIC_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  kgl_pkg::iss_ctl_t          iss_i,
  input  logic [CHAR_BITS-1:0]       chr_i,
  input  logic [CHAR_BITS-1:0]       pair_i,
  input  logic [5*METRIC_BITS+4*kgl_pkg::TEX_W-1:0] glyph_wdata_i,
  input  logic [METRIC_BITS-1:0]     kern_wdata_i,
  output logic                       clearing_o,
  output kgl_pkg::lkp_ctl_t          lkp_o,
  output logic [5*METRIC_BITS+4*kgl_pkg::TEX_W-1:0] glyph_rdata_o,
  output logic [METRIC_BITS-1:0]     kern_rdata_o
);
  import kgl_pkg::*;

  localparam int unsigned NCHARS  = 1 << CHAR_BITS;
  localparam int unsigned KADDR_W = 2 * CHAR_BITS;
  localparam int unsigned NPAIRS  = 1 << KADDR_W;
  localparam int unsigned GLYPH_W = 5 * METRIC_BITS + 4 * TEX_W;

  logic [NCHARS-1:0]    present_q;
  logic [CHAR_BITS-1:0] prev_q;
  logic                 have_prev_q;
  logic [KADDR_W-1:0]   clr_q;
  logic                 clearing_q;
  lkp_ctl_t             lkp_q;

  logic                 glyph_we;
  logic                 kern_we;
  logic [KADDR_W-1:0]   kern_waddr;
  logic [METRIC_BITS-1:0] kern_wdata;

  // Write strobes
  assign glyph_we   = iss_i.valid && (iss_i.op == OP_LOAD_GLYPH);
  assign kern_we    = clearing_q || (iss_i.valid && (iss_i.op == OP_LOAD_KERN));
  assign kern_waddr = clearing_q ? clr_q : {chr_i, pair_i};
  assign kern_wdata = clearing_q ? '0 : kern_wdata_i;

  kgl_ram #(
    .WIDTH (GLYPH_W),
    .DEPTH (NCHARS)
  ) u_glyph_ram (
    .clk_i   (clk_i),
    .we_i    (glyph_we),
    .waddr_i (chr_i),
    .wdata_i (glyph_wdata_i),
    .raddr_i (chr_i),
    .rdata_o (glyph_rdata_o)
  );

  // Pair table, read at (this character, previous character)
  kgl_ram #(
    .WIDTH (METRIC_BITS),
    .DEPTH (NPAIRS)
  ) u_kern_ram (
    .clk_i   (clk_i),
    .we_i    (kern_we),
    .waddr_i (kern_waddr),
    .wdata_i (kern_wdata),
    .raddr_i ({chr_i, prev_q}),
    .rdata_o (kern_rdata_o)
  );

  // Clear sweep over the pair table, one entry a cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q      <= '0;
      clearing_q <= 1'b1;
    end else if (clearing_q) begin
      clr_q <= clr_q + 1'b1;
      if (clr_q == KADDR_W'(NPAIRS - 1)) begin
        clearing_q <= 1'b0;
      end
    end
  end

  // Present bits and previous character
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      present_q   <= '0;
      prev_q      <= '0;
      have_prev_q <= 1'b0;
    end else if (iss_i.valid) begin
      case (iss_i.op)
        OP_LOAD_GLYPH: present_q[chr_i] <= 1'b1;
        OP_START: begin
          prev_q      <= '0;
          have_prev_q <= 1'b0;
        end
        OP_LAYOUT: begin
          prev_q      <= chr_i;
          have_prev_q <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // Lookup control, aligned with the RAM read data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lkp_q <= '0;
    end else begin
      lkp_q.valid     <= iss_i.valid;
      lkp_q.op        <= iss_i.op;
      lkp_q.is_space  <= iss_i.is_space;
      lkp_q.present   <= present_q[chr_i];
      lkp_q.have_prev <= have_prev_q;
    end
  end

  assign lkp_o      = lkp_q;
  assign clearing_o = clearing_q;

endmodule

// File: src/kgl_datapath.sv
// ----------------------------------------------------------------------------
// kgl_datapath
// Metric scaling, pen and height tracking and quad corner sums.
// ----------------------------------------------------------------------------
module kgl_datapath #(
  parameter int unsigned METRIC_BITS = kgl_pkg::METRIC_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  kgl_pkg::lkp_ctl_t          lkp_i,
  input  logic [5*METRIC_BITS+4*kgl_pkg::TEX_W-1:0] glyph_rdata_i,
  input  logic [METRIC_BITS-1:0]     kern_rdata_i,
  input  logic [kgl_pkg::SIZE_W-1:0] font_size_i,
  input  logic [kgl_pkg::SIZE_W-1:0] space_adv_i,
  output logic                       res_valid_o,
  output kgl_pkg::res_t              res_o
);
  import kgl_pkg::*;

  localparam int unsigned M        = METRIC_BITS;
  localparam int unsigned TEX_BITS = 4 * TEX_W;
  localparam int unsigned MUL_W    = (M > SIZE_W) ? M : SIZE_W;
  localparam int unsigned PRD_W    = MUL_W + SIZE_W + 1;
  localparam int unsigned SCL_W    = PRD_W - FRAC_SHIFT;

  // Q2.14 metric times Q12.4 size, rounded half up to Q15.4
  function automatic logic signed [SCL_W-1:0] scale(input logic signed [MUL_W-1:0] m,
                                                    input logic [SIZE_W-1:0] sz);
    logic signed [PRD_W-1:0] p;
    p = m * $signed({1'b0, sz});
    p = p + PRD_W'(ROUND_BIAS);
    return p[PRD_W-1:FRAC_SHIFT];
  endfunction

  // Glyph record fields
  logic signed [M-1:0]  g_top, g_left, g_height, g_width, g_adv;
  logic [TEX_BITS-1:0]  g_tex;
  logic                 s1_glyph;
  logic signed [MUL_W-1:0] m_kern, m_adv;

  assign g_tex    = glyph_rdata_i[TEX_BITS-1:0];
  assign g_top    = glyph_rdata_i[TEX_BITS +: M];
  assign g_left   = glyph_rdata_i[TEX_BITS+M +: M];
  assign g_height = glyph_rdata_i[TEX_BITS+2*M +: M];
  assign g_width  = glyph_rdata_i[TEX_BITS+3*M +: M];
  assign g_adv    = glyph_rdata_i[TEX_BITS+4*M +: M];

  assign s1_glyph = lkp_i.valid && (lkp_i.op == OP_LAYOUT) && !lkp_i.is_space &&
                    lkp_i.present;

  // Pen step before the glyph: space advance or pair kerning
  always_comb begin
    m_kern = '0;
    if ((lkp_i.op == OP_LAYOUT) && lkp_i.is_space) begin
      m_kern = MUL_W'($signed(space_adv_i));
    end else if (s1_glyph && lkp_i.have_prev) begin
      m_kern = MUL_W'($signed(kern_rdata_i));
    end
  end
  assign m_adv = s1_glyph ? MUL_W'(g_adv) : '0;

  // Stage 2: scaled metrics
  logic                    s2_valid_q, s2_glyph_q;
  op_e                     s2_op_q;
  logic signed [SCL_W-1:0] s2_kern_q, s2_adv_q, s2_left_q, s2_width_q, s2_top_q, s2_hgt_q;
  logic [TEX_BITS-1:0]     s2_tex_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else begin
      s2_valid_q <= lkp_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_op_q    <= lkp_i.op;
    s2_glyph_q <= s1_glyph;
    s2_kern_q  <= scale(m_kern, font_size_i);
    s2_adv_q   <= scale(m_adv, font_size_i);
    s2_left_q  <= scale(MUL_W'(g_left), font_size_i);
    s2_width_q <= scale(MUL_W'(g_width), font_size_i);
    s2_top_q   <= scale(MUL_W'(g_top), font_size_i);
    s2_hgt_q   <= scale(MUL_W'(g_height), font_size_i);
    s2_tex_q   <= g_tex;
  end

  // Pen and height state
  logic signed [POS_W-1:0] pen_q;
  logic [HGT_W-1:0]        max_q;

  // Stage 3: pen after kerning or space
  logic                    s3_valid_q, s3_glyph_q;
  op_e                     s3_op_q;
  logic signed [POS_W-1:0] s3_pen_q;
  logic signed [SCL_W-1:0] s3_adv_q, s3_left_q, s3_width_q, s3_top_q, s3_hgt_q;
  logic [TEX_BITS-1:0]     s3_tex_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
    end else begin
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s3_op_q    <= s2_op_q;
    s3_glyph_q <= s2_glyph_q;
    s3_pen_q   <= sat_add(pen_q, POS_W'(s2_kern_q));
    s3_adv_q   <= s2_adv_q;
    s3_left_q  <= s2_left_q;
    s3_width_q <= s2_width_q;
    s3_top_q   <= s2_top_q;
    s3_hgt_q   <= s2_hgt_q;
    s3_tex_q   <= s2_tex_q;
  end

  // Advance, left edge and running height
  logic signed [POS_W-1:0] pen_new, pen_after, left_x, hgt_ext;
  logic [HGT_W-1:0]        max_after;

  assign pen_new = sat_add(s3_pen_q, POS_W'(s3_adv_q));
  assign left_x  = sat_add(s3_pen_q, POS_W'(s3_left_q));
  assign hgt_ext = POS_W'(s3_hgt_q);

  always_comb begin
    pen_after = pen_new;
    max_after = max_q;
    if (s3_op_q == OP_START) begin
      pen_after = '0;
      max_after = '0;
    end else if (s3_glyph_q && ($signed({1'b0, max_q}) < hgt_ext)) begin
      max_after = hgt_ext[HGT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pen_q <= '0;
      max_q <= '0;
    end else if (s3_valid_q) begin
      pen_q <= pen_after;
      max_q <= max_after;
    end
  end

  // Stage 4: right and bottom corners
  logic                    s4_valid_q, s4_glyph_q;
  logic signed [POS_W-1:0] s4_left_q, s4_pen_q;
  logic signed [SCL_W-1:0] s4_width_q, s4_top_q, s4_hgt_q;
  logic [TEX_BITS-1:0]     s4_tex_q;
  logic [HGT_W-1:0]        s4_max_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_valid_q <= 1'b0;
    end else begin
      s4_valid_q <= s3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s4_glyph_q <= s3_glyph_q;
    s4_left_q  <= left_x;
    s4_pen_q   <= pen_after;
    s4_max_q   <= max_after;
    s4_width_q <= s3_width_q;
    s4_top_q   <= s3_top_q;
    s4_hgt_q   <= s3_hgt_q;
    s4_tex_q   <= s3_tex_q;
  end

  logic signed [POS_W-1:0] top_y;
  assign top_y = POS_W'(s4_top_q);

  // Result record; quad fields read zero when no quad
  always_comb begin
    res_o              = '0;
    res_o.quad_valid   = s4_glyph_q;
    res_o.pen_position = s4_pen_q;
    res_o.line_height  = s4_max_q;
    if (s4_glyph_q) begin
      res_o.quad_left   = s4_left_q;
      res_o.quad_right  = sat_add(s4_left_q, POS_W'(s4_width_q));
      res_o.quad_top    = top_y;
      res_o.quad_bottom = sat_sub(top_y, POS_W'(s4_hgt_q));
      res_o.out_s_low   = s4_tex_q[3*TEX_W +: TEX_W];
      res_o.out_t_low   = s4_tex_q[2*TEX_W +: TEX_W];
      res_o.out_s_high  = s4_tex_q[TEX_W +: TEX_W];
      res_o.out_t_high  = s4_tex_q[0 +: TEX_W];
    end
  end

  assign res_valid_o = s4_valid_q;

endmodule

// File: src/kgl_out_fifo.sv
// ----------------------------------------------------------------------------
// kgl_out_fifo
// Small result queue between the datapath and the result channel.
// ----------------------------------------------------------------------------
module kgl_out_fifo #(
  parameter int unsigned DEPTH = kgl_pkg::FIFO_DEPTH
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  kgl_pkg::res_t data_i,
  output logic          valid_o,
  input  logic          ready_i,
  output kgl_pkg::res_t data_o
);
  import kgl_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  res_t          mem_q [DEPTH];
  logic [AW-1:0] wptr_q, rptr_q;
  logic [CW-1:0] count_q;
  logic          pop;

  assign pop     = valid_o && ready_i;
  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= data_i;
    end
  end

  // Pointers wrap at the depth; the issue credit keeps the queue from overflowing
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= (wptr_q == AW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (pop) begin
        rptr_q <= (rptr_q == AW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
      end
      if (push_i && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (!push_i && pop) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

// File: src/kerned_glyph_layout.sv
// ----------------------------------------------------------------------------
// kerned_glyph_layout
// Bitmap font text layout with pair kerning, fixed point, one quad record
// per request.
//
//   channel  | role | handshake    | payload
//   ---------+------+--------------+-----------------------------------------
//   req_if   | sink | valid/ready  | request type, character, metrics, texels
//   quad_if  | src  | valid/ready  | quad corners, texels, pen x, line height
//   cfg_if   | sink | valid/ready  | register index, write data
//
// Two requests are never taken back to back; the pen update (two saturating
// adds, one per cycle) needs that gap. A result passes the table read,
// scaling, pen step, advance and corner sums, in that order, and then a
// four-entry result queue; requests are held off while four are in flight
// or queued. After reset the kerning table is swept to zero, one entry a
// cycle over all 2**(2*CHAR_BITS) entries (16384 by default), with
// req_if.ready low; register writes are taken throughout.
// ----------------------------------------------------------------------------
module kerned_glyph_layout #(
  parameter int unsigned CHAR_BITS   = kgl_pkg::CHAR_BITS_DEF,
  parameter int unsigned METRIC_BITS = kgl_pkg::METRIC_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  kgl_req_if.sink     req_if,
  kgl_quad_if.source  quad_if,
  kgl_cfg_if.sink     cfg_if
);
  import kgl_pkg::*;

  localparam int unsigned GLYPH_W = 5 * METRIC_BITS + 4 * TEX_W;
  localparam int unsigned CRD_W   = $clog2(FIFO_DEPTH + 1);

  logic [SIZE_W-1:0] font_size_q, space_adv_q;
  logic              gap_q;
  logic [CRD_W-1:0]  credit_q, credit_d;
  logic              clearing;
  logic              accept, pop;
  iss_ctl_t          iss;
  lkp_ctl_t          lkp;
  logic [GLYPH_W-1:0]     glyph_wdata, glyph_rdata;
  logic [METRIC_BITS-1:0] kern_rdata;
  logic              res_valid;
  res_t              res, out_res;

  // Request handshake
  assign req_if.ready = !clearing && !gap_q && (credit_q < CRD_W'(FIFO_DEPTH));
  assign accept       = req_if.valid && req_if.ready;
  assign pop          = quad_if.valid && quad_if.ready;

  assign iss.valid    = accept;
  assign iss.op       = op_e'(req_if.req_type);
  assign iss.is_space = (32'(req_if.char_code) == SPACE_CODE);

  assign glyph_wdata = {req_if.advance_or_kern, req_if.box_width, req_if.box_height,
                        req_if.bearing_left, req_if.bearing_top, req_if.tex_s_low,
                        req_if.tex_t_low, req_if.tex_s_high, req_if.tex_t_high};

  // Requests in flight plus queued results
  always_comb begin
    credit_d = credit_q;
    if (accept && !pop) begin
      credit_d = credit_q + 1'b1;
    end else if (!accept && pop) begin
      credit_d = credit_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gap_q    <= 1'b0;
      credit_q <= '0;
    end else begin
      gap_q    <= accept;
      credit_q <= credit_d;
    end
  end

  // Register writes
  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      font_size_q <= FONT_SIZE_RST;
      space_adv_q <= SPACE_ADV_RST;
    end else if (cfg_if.valid && cfg_if.ready) begin
      case (cfg_if.idx)
        REG_FONT_SIZE: font_size_q <= cfg_if.wdata;
        REG_SPACE_ADV: space_adv_q <= cfg_if.wdata;
        default: ;
      endcase
    end
  end

  kgl_store #(
    .CHAR_BITS   (CHAR_BITS),
    .METRIC_BITS (METRIC_BITS)
  ) u_store (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .iss_i         (iss),
    .chr_i         (req_if.char_code),
    .pair_i        (req_if.pair_char),
    .glyph_wdata_i (glyph_wdata),
    .kern_wdata_i  (req_if.advance_or_kern),
    .clearing_o    (clearing),
    .lkp_o         (lkp),
    .glyph_rdata_o (glyph_rdata),
    .kern_rdata_o  (kern_rdata)
  );

  kgl_datapath #(
    .METRIC_BITS (METRIC_BITS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .lkp_i         (lkp),
    .glyph_rdata_i (glyph_rdata),
    .kern_rdata_i  (kern_rdata),
    .font_size_i   (font_size_q),
    .space_adv_i   (space_adv_q),
    .res_valid_o   (res_valid),
    .res_o         (res)
  );

  kgl_out_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_valid),
    .data_i  (res),
    .valid_o (quad_if.valid),
    .ready_i (quad_if.ready),
    .data_o  (out_res)
  );

  // Result channel
  assign quad_if.quad_valid   = out_res.quad_valid;
  assign quad_if.quad_left    = out_res.quad_left;
  assign quad_if.quad_right   = out_res.quad_right;
  assign quad_if.quad_top     = out_res.quad_top;
  assign quad_if.quad_bottom  = out_res.quad_bottom;
  assign quad_if.out_s_low    = out_res.out_s_low;
  assign quad_if.out_t_low    = out_res.out_t_low;
  assign quad_if.out_s_high   = out_res.out_s_high;
  assign quad_if.out_t_high   = out_res.out_t_high;
  assign quad_if.pen_position = out_res.pen_position;
  assign quad_if.line_height  = out_res.line_height;

endmodule

// File: src/kgl_checker.sv
// ----------------------------------------------------------------------------
// kgl_checker
// Port-level checks on the glyph layout block, bound to the top level.
// ----------------------------------------------------------------------------
module kgl_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             req_valid_i,
  input logic                             req_ready_i,
  input logic                             out_valid_i,
  input logic                             out_ready_i,
  input logic                             quad_valid_i,
  input logic signed [kgl_pkg::POS_W-1:0] quad_left_i,
  input logic signed [kgl_pkg::POS_W-1:0] quad_right_i,
  input logic signed [kgl_pkg::POS_W-1:0] quad_top_i,
  input logic signed [kgl_pkg::POS_W-1:0] quad_bottom_i,
  input logic [kgl_pkg::TEX_W-1:0]        out_s_low_i,
  input logic [kgl_pkg::TEX_W-1:0]        out_t_low_i,
  input logic [kgl_pkg::TEX_W-1:0]        out_s_high_i,
  input logic [kgl_pkg::TEX_W-1:0]        out_t_high_i,
  input logic signed [kgl_pkg::POS_W-1:0] pen_position_i,
  input logic [kgl_pkg::HGT_W-1:0]        line_height_i
);
  import kgl_pkg::*;

  logic signed [POS_W-1:0] quad_span;
  assign quad_span = quad_top_i - quad_bottom_i;

  // Requests are never accepted back to back
  a_issue_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("request taken in two consecutive cycles");

  // A stalled result stays valid and holds its pen position, left edge and line height
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(pen_position_i) &&
    $stable(quad_left_i) && $stable(line_height_i))
    else $error("stalled result changed");

  // No quad: corners and texels read zero
  a_empty_quad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !quad_valid_i |-> quad_left_i == 0 && quad_right_i == 0 &&
    quad_top_i == 0 && quad_bottom_i == 0 && out_s_low_i == 0 && out_t_low_i == 0 &&
    out_s_high_i == 0 && out_t_high_i == 0)
    else $error("empty result carries quad data");

  // Line height covers the height of every quad reported
  a_height_cover: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && quad_valid_i |-> $signed({1'b0, line_height_i}) >= quad_span)
    else $error("line height below quad height");

endmodule

bind kerned_glyph_layout kgl_checker u_kgl_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .req_valid_i    (req_if.valid),
  .req_ready_i    (req_if.ready),
  .out_valid_i    (quad_if.valid),
  .out_ready_i    (quad_if.ready),
  .quad_valid_i   (quad_if.quad_valid),
  .quad_left_i    (quad_if.quad_left),
  .quad_right_i   (quad_if.quad_right),
  .quad_top_i     (quad_if.quad_top),
  .quad_bottom_i  (quad_if.quad_bottom),
  .out_s_low_i    (quad_if.out_s_low),
  .out_t_low_i    (quad_if.out_t_low),
  .out_s_high_i   (quad_if.out_s_high),
  .out_t_high_i   (quad_if.out_t_high),
  .pen_position_i (quad_if.pen_position),
  .line_height_i  (quad_if.line_height)
);

// File: tb/kerned_glyph_layout_test.sv
// ----------------------------------------------------------------------------
// kerned_glyph_layout_test
// Self-checking bench for the kerned glyph layout block. A scoreboard class
// tracks the glyph and kerning tables, pen and height, and predicts one quad
// record per accepted request. A directed run covers field extremes, every
// request type, spaces, unknown characters, reloads and negative heights.
// Random phases at several register settings follow, with idle bursts on
// both channels.
// ----------------------------------------------------------------------------
module kerned_glyph_layout_test;
  import kgl_pkg::*;

  localparam int unsigned CB     = CHAR_BITS_DEF;
  localparam int unsigned MB     = METRIC_BITS_DEF;
  localparam int unsigned NCODES = 1 << CB;
  localparam int unsigned NPAIRS = 1 << (2 * CB);
  localparam int unsigned PHASES = 8;
  localparam int unsigned PHASE_ITEMS = 125;

  // One request as the bench sees it
  typedef struct packed {
    op_e                  op;
    logic [CB-1:0]        code;
    logic [CB-1:0]        pair;
    logic signed [MB-1:0] aok;
    logic signed [MB-1:0] bw;
    logic signed [MB-1:0] bh;
    logic signed [MB-1:0] bl;
    logic signed [MB-1:0] bt;
    logic [TEX_W-1:0]     s0;
    logic [TEX_W-1:0]     t0;
    logic [TEX_W-1:0]     s1;
    logic [TEX_W-1:0]     t1;
  } layout_req_t;

  // Layout tracker: table copies, pen state and the quads still owed
  class layout_tracker;
    logic [SIZE_W-1:0]    font_size;
    logic signed [15:0]   space_adv;
    bit                   present[NCODES];
    logic signed [MB-1:0] adv[NCODES];
    logic signed [MB-1:0] box_w[NCODES];
    logic signed [MB-1:0] box_h[NCODES];
    logic signed [MB-1:0] bear_l[NCODES];
    logic signed [MB-1:0] bear_t[NCODES];
    logic [TEX_W-1:0]     s_lo[NCODES];
    logic [TEX_W-1:0]     t_lo[NCODES];
    logic [TEX_W-1:0]     s_hi[NCODES];
    logic [TEX_W-1:0]     t_hi[NCODES];
    logic signed [MB-1:0] kern[NPAIRS];
    logic [CB-1:0]        prev_code;
    bit                   have_prev;
    int                   pen;
    int                   max_h;
    res_t                 quads_due[$];
    int                   mismatches;
    int                   strays;
    int                   results_seen;

    function new();
      font_size = FONT_SIZE_RST;
      space_adv = SPACE_ADV_RST;
      foreach (present[i]) present[i] = 1'b0;
      foreach (kern[i]) kern[i] = '0;
      prev_code    = '0;
      have_prev    = 1'b0;
      pen          = 0;
      max_h        = 0;
      mismatches   = 0;
      strays       = 0;
      results_seen = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_FONT_SIZE: font_size = val;
        REG_SPACE_ADV: space_adv = val;
        default: ;
      endcase
    endfunction

    // Q2.14 times Q12.4, rounded half up into Q15.4
    function longint scaled(logic signed [MB-1:0] m);
      longint p;
      p = longint'(m) * longint'({48'd0, font_size});
      return (p + 64'sd8192) >>> FRAC_SHIFT;
    endfunction

    function int clamp32(longint v);
      if (v > 64'sd2147483647) return 32'sh7fffffff;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return int'(v);
    endfunction

    function int pending();
      return quads_due.size();
    endfunction

    // Apply one accepted request and queue the quad record it owes
    function void take_request(layout_req_t rq);
      res_t   q;
      longint h;
      int     l;
      int     t;
      q = '0;
      case (rq.op)
        OP_LOAD_GLYPH: begin
          present[rq.code] = 1'b1;
          adv[rq.code]     = rq.aok;
          box_w[rq.code]   = rq.bw;
          box_h[rq.code]   = rq.bh;
          bear_l[rq.code]  = rq.bl;
          bear_t[rq.code]  = rq.bt;
          s_lo[rq.code]    = rq.s0;
          t_lo[rq.code]    = rq.t0;
          s_hi[rq.code]    = rq.s1;
          t_hi[rq.code]    = rq.t1;
        end
        OP_LOAD_KERN: kern[{rq.code, rq.pair}] = rq.aok;
        OP_START: begin
          pen       = 0;
          max_h     = 0;
          have_prev = 1'b0;
          prev_code = '0;
        end
        default: begin
          if (rq.code == CB'(SPACE_CODE)) begin
            pen = clamp32(longint'(pen) + scaled(space_adv));
          end else if (present[rq.code]) begin
            if (have_prev) begin
              pen = clamp32(longint'(pen) + scaled(kern[{rq.code, prev_code}]));
            end
            h = scaled(box_h[rq.code]);
            l = clamp32(longint'(pen) + scaled(bear_l[rq.code]));
            t = clamp32(scaled(bear_t[rq.code]));
            q.quad_valid  = 1'b1;
            q.quad_left   = l;
            q.quad_right  = clamp32(longint'(l) + scaled(box_w[rq.code]));
            q.quad_top    = t;
            q.quad_bottom = clamp32(longint'(t) - h);
            q.out_s_low   = s_lo[rq.code];
            q.out_t_low   = t_lo[rq.code];
            q.out_s_high  = s_hi[rq.code];
            q.out_t_high  = t_hi[rq.code];
            pen = clamp32(longint'(pen) + scaled(adv[rq.code]));
            if (h > longint'(max_h)) max_h = clamp32(h);
          end
          prev_code = rq.code;
          have_prev = 1'b1;
        end
      endcase
      q.pen_position = pen;
      q.line_height  = max_h[HGT_W-1:0];
      quads_due.insert(quads_due.size(), q);
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch in %s of result %0d: expected %h, got %h",
                   name, results_seen, want, got);
        end
      end
    endfunction

    // Compare one accepted quad record with the oldest one owed
    function void match_quad(res_t got);
      res_t want;
      if (quads_due.size() == 0) begin
        strays++;
        $display("result %0d arrived with no request outstanding", results_seen);
      end else begin
        want = quads_due.pop_front();
        compare_field("quad_valid", want.quad_valid, got.quad_valid);
        compare_field("quad_left", want.quad_left, got.quad_left);
        compare_field("quad_right", want.quad_right, got.quad_right);
        compare_field("quad_top", want.quad_top, got.quad_top);
        compare_field("quad_bottom", want.quad_bottom, got.quad_bottom);
        compare_field("out_s_low", want.out_s_low, got.out_s_low);
        compare_field("out_t_low", want.out_t_low, got.out_t_low);
        compare_field("out_s_high", want.out_s_high, got.out_s_high);
        compare_field("out_t_high", want.out_t_high, got.out_t_high);
        compare_field("pen_position", want.pen_position, got.pen_position);
        compare_field("line_height", want.line_height, got.line_height);
      end
      results_seen++;
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  bit   calm;

  kgl_req_if #(.CHAR_BITS(CB), .METRIC_BITS(MB)) req_ch ();
  kgl_quad_if quad_ch ();
  kgl_cfg_if  cfg_ch ();

  kerned_glyph_layout #(
    .CHAR_BITS   (CB),
    .METRIC_BITS (MB)
  ) dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_if  (req_ch),
    .quad_if (quad_ch),
    .cfg_if  (cfg_ch)
  );

  layout_tracker board = new();
  logic [CB-1:0] alphabet[12];

  // Clock and reset
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    rst_ni <= 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Run limit
  initial begin
    #2000000;
    $display("DONE: errors detected");
    $finish;
  end

  // Result side: ready with random stall bursts, none once calm
  initial begin
    int stall;
    stall = 0;
    quad_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (stall > 0) begin
        stall--;
        quad_ch.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        stall = $urandom_range(1, 12) - 1;
        quad_ch.ready <= 1'b0;
      end else begin
        quad_ch.ready <= 1'b1;
      end
    end
  end

  // Result monitor
  always @(posedge clk_i) begin
    res_t got;
    if (rst_ni && quad_ch.valid === 1'b1 && quad_ch.ready === 1'b1) begin
      got.quad_valid   = quad_ch.quad_valid;
      got.quad_left    = quad_ch.quad_left;
      got.quad_right   = quad_ch.quad_right;
      got.quad_top     = quad_ch.quad_top;
      got.quad_bottom  = quad_ch.quad_bottom;
      got.out_s_low    = quad_ch.out_s_low;
      got.out_t_low    = quad_ch.out_t_low;
      got.out_s_high   = quad_ch.out_s_high;
      got.out_t_high   = quad_ch.out_t_high;
      got.pen_position = quad_ch.pen_position;
      got.line_height  = quad_ch.line_height;
      board.match_quad(got);
    end
  end

  // Send one request, optionally after an idle burst; valid stays high after
  task automatic send_request(layout_req_t rq);
    if (!calm && $urandom_range(0, 5) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
    req_ch.valid           <= 1'b1;
    req_ch.req_type        <= rq.op;
    req_ch.char_code       <= rq.code;
    req_ch.pair_char       <= rq.pair;
    req_ch.advance_or_kern <= rq.aok;
    req_ch.box_width       <= rq.bw;
    req_ch.box_height      <= rq.bh;
    req_ch.bearing_left    <= rq.bl;
    req_ch.bearing_top     <= rq.bt;
    req_ch.tex_s_low       <= rq.s0;
    req_ch.tex_t_low       <= rq.t0;
    req_ch.tex_s_high      <= rq.s1;
    req_ch.tex_t_high      <= rq.t1;
    do @(posedge clk_i); while (req_ch.ready !== 1'b1);
    board.take_request(rq);
  endtask

  // Drop the request valid and wait until every quad owed has come back
  task automatic drain_requests();
    req_ch.valid <= 1'b0;
    do @(posedge clk_i); while (board.pending() != 0);
  endtask

  // Write both registers back to back; only while the block is idle
  task automatic write_regs(logic [CFG_DATA_W-1:0] size, logic [CFG_DATA_W-1:0] spc);
    cfg_ch.valid <= 1'b1;
    cfg_ch.idx   <= REG_FONT_SIZE;
    cfg_ch.wdata <= size;
    do @(posedge clk_i); while (cfg_ch.ready !== 1'b1);
    board.set_reg(REG_FONT_SIZE, size);
    cfg_ch.idx   <= REG_SPACE_ADV;
    cfg_ch.wdata <= spc;
    do @(posedge clk_i); while (cfg_ch.ready !== 1'b1);
    board.set_reg(REG_SPACE_ADV, spc);
    cfg_ch.valid <= 1'b0;
  endtask

  // Request builders; unused fields carry random bits
  function automatic layout_req_t noise_req();
    layout_req_t rq;
    rq.op   = op_e'($urandom_range(0, 3));
    rq.code = CB'($urandom);
    rq.pair = CB'($urandom);
    rq.aok  = MB'($urandom);
    rq.bw   = MB'($urandom);
    rq.bh   = MB'($urandom);
    rq.bl   = MB'($urandom);
    rq.bt   = MB'($urandom);
    rq.s0   = TEX_W'($urandom);
    rq.t0   = TEX_W'($urandom);
    rq.s1   = TEX_W'($urandom);
    rq.t1   = TEX_W'($urandom);
    return rq;
  endfunction

  function automatic layout_req_t glyph_req(logic [CB-1:0] code, logic [MB-1:0] aok,
                                            logic [MB-1:0] bw, logic [MB-1:0] bh,
                                            logic [MB-1:0] bl, logic [MB-1:0] bt,
                                            logic [TEX_W-1:0] s0, logic [TEX_W-1:0] t0,
                                            logic [TEX_W-1:0] s1, logic [TEX_W-1:0] t1);
    layout_req_t rq;
    rq      = noise_req();
    rq.op   = OP_LOAD_GLYPH;
    rq.code = code;
    rq.aok  = aok;
    rq.bw   = bw;
    rq.bh   = bh;
    rq.bl   = bl;
    rq.bt   = bt;
    rq.s0   = s0;
    rq.t0   = t0;
    rq.s1   = s1;
    rq.t1   = t1;
    return rq;
  endfunction

  function automatic layout_req_t kern_req(logic [CB-1:0] code, logic [CB-1:0] pair,
                                           logic [MB-1:0] k);
    layout_req_t rq;
    rq      = noise_req();
    rq.op   = OP_LOAD_KERN;
    rq.code = code;
    rq.pair = pair;
    rq.aok  = k;
    return rq;
  endfunction

  function automatic layout_req_t op_req(op_e op, logic [CB-1:0] code);
    layout_req_t rq;
    rq      = noise_req();
    rq.op   = op;
    rq.code = code;
    return rq;
  endfunction

  // Metrics: mostly modest values, some full range, some extremes
  function automatic logic [MB-1:0] pick_metric();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0: return 16'h8000;
          1: return 16'h7fff;
          2: return 16'h0000;
          default: return 16'hffff;
        endcase
      end
      1, 2: return MB'($urandom);
      3: return MB'(-$signed($urandom_range(0, 8192)));
      default: return MB'($urandom_range(0, 20000));
    endcase
  endfunction

  function automatic logic [CB-1:0] pick_char();
    case ($urandom_range(0, 19))
      0, 1, 2: return CB'(SPACE_CODE);
      3:       return CB'($urandom);
      default: return alphabet[$urandom_range(0, 11)];
    endcase
  endfunction

  task automatic load_random_glyph(logic [CB-1:0] code);
    send_request(glyph_req(code, pick_metric(), pick_metric(), pick_metric(),
                           pick_metric(), pick_metric(), TEX_W'($urandom),
                           TEX_W'($urandom), TEX_W'($urandom), TEX_W'($urandom)));
  endtask

  // One random phase: eight glyph loads, then mostly strings mixed with loads and noise requests
  task automatic run_phase(int n_items);
    int sent;
    int len;
    foreach (alphabet[i]) alphabet[i] = CB'($urandom);
    foreach (alphabet[i]) begin
      if (i < 8) load_random_glyph(alphabet[i]);
    end
    sent = 8;
    while (sent < n_items) begin
      case ($urandom_range(0, 99)) inside
        [0:14]: begin
          load_random_glyph(pick_char());
          sent++;
        end
        [15:27]: begin
          send_request(kern_req(pick_char(), pick_char(), pick_metric()));
          sent++;
        end
        [28:84]: begin
          if ($urandom_range(0, 4) != 0) begin
            send_request(op_req(OP_START, CB'($urandom)));
            sent++;
          end
          len = $urandom_range(3, 12);
          repeat (len) begin
            send_request(op_req(OP_LAYOUT, pick_char()));
            sent++;
          end
        end
        default: begin
          send_request(noise_req());
          sent++;
        end
      endcase
    end
  endtask

  // Stimulus
  initial begin
    req_ch.valid <= 1'b0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.idx   <= REG_FONT_SIZE;
    cfg_ch.wdata <= '0;
    {req_ch.req_type, req_ch.char_code, req_ch.pair_char} <= '0;
    {req_ch.advance_or_kern, req_ch.box_width, req_ch.box_height} <= '0;
    {req_ch.bearing_left, req_ch.bearing_top} <= '0;
    {req_ch.tex_s_low, req_ch.tex_t_low, req_ch.tex_s_high, req_ch.tex_t_high} <= '0;
    calm = 1'b0;
    @(posedge rst_ni);
    @(posedge clk_i);
    write_regs(FONT_SIZE_RST, SPACE_ADV_RST);

    // Directed: unknown character straight after reset, no start
    send_request(op_req(OP_LAYOUT, 7'd65));
    // Extreme metrics; the first glyph has a negative height
    send_request(glyph_req(7'd65, 16'h7fff, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff,
                           16'hffff, 16'h0000, 16'hffff, 16'h0000));
    send_request(glyph_req(7'd66, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000,
                           16'h0000, 16'hffff, 16'h0000, 16'hffff));
    // A glyph for the space code is stored but must not be used
    send_request(glyph_req(7'd32, 16'h4000, 16'h4000, 16'h4000, 16'h0100, 16'h0200,
                           16'h1111, 16'h2222, 16'h3333, 16'h4444));
    send_request(glyph_req(7'd0, 16'h0800, 16'h0400, 16'h0c00, 16'hff00, 16'h0a00,
                           16'h0001, 16'h0002, 16'h0003, 16'h0004));
    send_request(glyph_req(7'd127, 16'h1000, 16'h0800, 16'h2000, 16'h0040, 16'h1800,
                           16'h8000, 16'h7fff, 16'hfffe, 16'h0001));
    send_request(kern_req(7'd66, 7'd65, 16'h7fff));
    send_request(kern_req(7'd65, 7'd66, 16'h8000));
    send_request(kern_req(7'd0, 7'd127, 16'hf000));
    send_request(kern_req(7'd127, 7'd0, 16'h0123));
    send_request(op_req(OP_START, 7'd0));
    send_request(op_req(OP_LAYOUT, 7'd65));
    send_request(op_req(OP_LAYOUT, 7'd66));
    send_request(op_req(OP_LAYOUT, 7'd65));
    send_request(op_req(OP_LAYOUT, 7'd32));
    send_request(op_req(OP_LAYOUT, 7'd66));
    send_request(op_req(OP_LAYOUT, 7'd5));
    send_request(op_req(OP_LAYOUT, 7'd127));
    send_request(op_req(OP_LAYOUT, 7'd0));
    send_request(op_req(OP_LAYOUT, 7'd127));
    send_request(op_req(OP_START, 7'd127));
    // Reloads overwrite the earlier glyph and load a new pair
    send_request(glyph_req(7'd65, 16'h0400, 16'h0200, 16'h0300, 16'h0010, 16'h0300,
                           16'h0a0a, 16'h0b0b, 16'h0c0c, 16'h0d0d));
    send_request(kern_req(7'd65, 7'd127, 16'h0020));
    send_request(op_req(OP_LAYOUT, 7'd127));
    send_request(op_req(OP_LAYOUT, 7'd65));

    // Random phases, the first ones at the register extremes
    for (int ph = 0; ph < PHASES; ph++) begin
      drain_requests();
      case (ph)
        0:       write_regs(16'hffff, 16'h7fff);
        1:       write_regs(16'h0000, 16'h8000);
        2:       write_regs(16'h0001, 16'hffff);
        3:       write_regs(16'h0010, 16'h0000);
        default: write_regs(CFG_DATA_W'($urandom_range(1, 2048)), CFG_DATA_W'($urandom));
      endcase
      if (ph == PHASES - 1) calm = 1'b1;
      run_phase(PHASE_ITEMS);
    end

    // Wind down
    drain_requests();
    repeat (12) @(posedge clk_i);
    if (board.mismatches == 0 && board.strays == 0 && board.pending() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
